[hw/rtl/assert_macros.svh]
// Assertion helpers. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CHK_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define CHK_IMPL(lbl, ck, rn, ante, cons)
`define CHK_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

[hw/rtl/pth_pkg.sv]
`default_nettype none

package pth_pkg;

  // sizing
  localparam int NUM_BINS     = 256;
  localparam int TEMPLATE_LEN = 64;

  localparam int BA_W   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int TA_W   = (TEMPLATE_LEN > 1) ? $clog2(TEMPLATE_LEN) : 1;
  localparam int NB_W   = $clog2(NUM_BINS + 1);
  localparam int NE_W   = $clog2(TEMPLATE_LEN + 1);
  localparam int SUMX_W = 16 + NE_W;
  localparam int SUM_W  = 22;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // register reset values
  localparam logic [31:0] RST_WINDOW_START    = 32'd0;
  localparam logic [15:0] RST_BIN_WIDTH       = 16'd1;
  localparam logic [8:0]  RST_BINS_IN_USE     = 9'd256;
  localparam logic [6:0]  RST_TEMPLATE_LENGTH = 7'd64;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_DEPOSIT = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_SKIPPED   = 2'd1,
    STAT_RANGE     = 2'd2,
    STAT_SATURATED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_WINDOW_START    = 3'd0,
    CFG_BIN_WIDTH       = 3'd1,
    CFG_BINS_IN_USE     = 3'd2,
    CFG_TEMPLATE_LENGTH = 3'd3
  } cfg_idx_t;

endpackage

`default_nettype wire

[hw/rtl/pth_ram.sv]
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module pth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/pulse_template_histogram_splat.sv]
`default_nettype none
`include "assert_macros.svh"

// Channel     | Ports                                   | Direction | Handshake
// ------------+-----------------------------------------+-----------+------------------------
// input       | in_action .. in_pulse_amplitude         | in        | start & !busy
// result      | out_bin_value, out_status               | out       | out_strobe, one cycle
// config      | cfg_index, cfg_wdata                    | in        | cfg_we, no wait
//
// Load, clear and out-of-range read: result in the next cycle, busy stays low.
// Read: the result waits in S_RDOUT for the registered bin memory read.
// Deposit: a template sum sweep over the used entries, the 41-step position divider, then
//   for each entry whose bin pair touches the active range the 32-step quotient dividers
//   and the bin updates; the other entries are passed over.
// Reset is synchronous; no clearing pass, valid bits clear both stores at once.
// The receiver cannot stall: each result transaction is shown for exactly one cycle.

module pulse_template_histogram_splat (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_entry_index,
  input  logic [15:0]        in_template_value,
  input  logic signed [31:0] in_pulse_time,
  input  logic [19:0]        in_pulse_amplitude,
  // result channel
  output logic               out_strobe,
  output logic [31:0]        out_bin_value,
  output logic [1:0]         out_status,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int POS_STEPS = 41;  // quotient bits of the bin position
  localparam int Q_STEPS   = 32;  // quotient bits of one deposit share
  localparam int CNT_W     = $clog2(POS_STEPS + 1);

  localparam int BA_W = pth_pkg::BA_W;
  localparam int TA_W = pth_pkg::TA_W;
  localparam int NB_W = pth_pkg::NB_W;
  localparam int NE_W = pth_pkg::NE_W;
  localparam int SX_W = pth_pkg::SUMX_W;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_RDOUT = 15'h0002,
    S_SUM   = 15'h0004,
    S_CHECK = 15'h0008,
    S_PDIV  = 15'h0010,
    S_POS   = 15'h0020,
    S_ERD   = 15'h0040,
    S_EMUL1 = 15'h0080,
    S_EMUL2 = 15'h0100,
    S_ELOAD = 15'h0200,
    S_EDIV  = 15'h0400,
    S_BRD   = 15'h0800,
    S_BW0   = 15'h1000,
    S_BW1   = 15'h2000,
    S_NEXT  = 15'h4000
  } state_t;

  typedef struct packed {
    logic [29:0] rem;
    logic        qbit;
  } div_step_t;

  // one restoring division step
  function automatic div_step_t div_step(input logic [29:0] rem, input logic nbit,
                                         input logic [29:0] dvs);
    div_step_t   res;
    logic [30:0] trial;
    trial = {rem, nbit};
    if (trial >= {1'b0, dvs}) begin
      res.rem  = 30'(trial - {1'b0, dvs});
      res.qbit = 1'b1;
    end else begin
      res.rem  = trial[29:0];
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] ws_r;
  logic [15:0] bw_r;
  logic [8:0]  biu_r;
  logic [6:0]  tl_r;

  logic [NB_W-1:0] nb_eff;   // active bins
  logic [NE_W-1:0] ne_eff;   // used template entries

  assign nb_eff = (32'(biu_r) < pth_pkg::NUM_BINS) ? NB_W'(biu_r)
                                                    : NB_W'(pth_pkg::NUM_BINS);
  assign ne_eff = (32'(tl_r) < pth_pkg::TEMPLATE_LEN) ? NE_W'(tl_r)
                                                       : NE_W'(pth_pkg::TEMPLATE_LEN);

  // ---------------------------------------------------------------------------
  // state
  // ---------------------------------------------------------------------------
  state_t state_r, state_nxt;

  logic               out_strobe_r, out_strobe_nxt;
  logic [31:0]        out_value_r, out_value_nxt;
  pth_pkg::status_t   out_status_r, out_status_nxt;

  logic [19:0]        amp_r, amp_nxt;
  logic [32:0]        diff_r, diff_nxt;     // pulse_time - window_start
  logic [SX_W-1:0]    acc_r, acc_nxt;       // template sum sweep
  logic [21:0]        sum_r, sum_nxt;       // saturated template sum
  logic               pend_r, pend_nxt;
  logic [NE_W-1:0]    ent_r, ent_nxt;

  logic [29:0]        dv_r, dv_nxt;         // shared divisor
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [29:0]        da_rem_r, da_rem_nxt;
  logic [40:0]        da_num_r, da_num_nxt;
  logic [40:0]        da_q_r, da_q_nxt;
  logic [29:0]        db_rem_r, db_rem_nxt;
  logic [31:0]        db_num_r, db_num_nxt;
  logic [31:0]        db_q_r, db_q_nxt;

  logic [34:0]        bidx_r, bidx_nxt;     // signed bin of the current entry
  logic [7:0]         frac_r, frac_nxt;
  logic [35:0]        k_r, k_nxt;           // amplitude * bin width
  logic [51:0]        base_r, base_nxt;
  logic [60:0]        nl_r, nl_nxt;
  logic [60:0]        nr_r, nr_nxt;
  logic               satl_r, satl_nxt;
  logic               satr_r, satr_nxt;
  logic               in0_r, in0_nxt;
  logic               in1_r, in1_nxt;
  logic               sat_any_r, sat_any_nxt;

  // memories
  logic                 tpl_we;
  logic [TA_W-1:0]      tpl_waddr;
  logic [TA_W-1:0]      tpl_raddr;
  logic [15:0]          tpl_rdata;
  logic [15:0]          tpl_rd;
  logic [pth_pkg::TEMPLATE_LEN-1:0] tpl_vld_r;
  logic                 tpl_vld_q_r;

  logic                 bin_we;
  logic                 bin_clr;
  logic [BA_W-1:0]      bin_waddr;
  logic [31:0]          bin_wdata;
  logic [BA_W-1:0]      bin_raddr;
  logic [31:0]          bin_rdata;
  logic [31:0]          bin_rd;
  logic [pth_pkg::NUM_BINS-1:0] bin_vld_r;
  logic                 bin_vld_q_r;

  // datapath helpers
  logic               accept;
  logic [34:0]        bidx1;
  logic               in0_now, in1_now;
  logic [21:0]        sum_sat;
  logic [29:0]        den;
  logic [28:0]        half;
  logic [32:0]        mag;
  logic [41:0]        pos;
  logic [8:0]         wl;
  div_step_t          step_a, step_b;
  logic [35:0]        k_prod;
  logic [51:0]        base_prod;
  logic [60:0]        nl_prod, nr_prod;
  logic [31:0]        add_q;
  logic               add_ovf;
  logic [32:0]        add_sum;
  logic               add_sat;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign tpl_rd = tpl_vld_q_r ? tpl_rdata : 16'd0;
  assign bin_rd = bin_vld_q_r ? bin_rdata : 32'd0;

  assign sum_sat = (32'(acc_r) > 32'(pth_pkg::SUM_MAX)) ? pth_pkg::SUM_MAX : 22'(acc_r);
  assign den     = {sum_r, 8'd0};
  assign half    = {sum_r, 7'd0};

  assign mag = diff_r[32] ? (~diff_r + 33'd1) : diff_r;

  // floor for negative offsets: -(q + (r != 0)) = ~q + (r == 0)
  assign pos = neg_pos() ? ({1'b1, ~da_q_r} + 42'(da_rem_r == 30'd0)) : {1'b0, da_q_r};

  function automatic logic neg_pos();
    return diff_r[32];
  endfunction

  assign bidx1   = bidx_r + 35'd1;
  assign in0_now = !bidx_r[34] && (bidx_r[33:0] < 34'(nb_eff));
  assign in1_now = !bidx1[34] && (bidx1[33:0] < 34'(nb_eff));

  assign step_a = div_step(da_rem_r, da_num_r[40], dv_r);
  assign step_b = div_step(db_rem_r, db_num_r[31], dv_r);

  assign wl        = 9'd256 - {1'b0, frac_r};
  assign k_prod    = 36'(amp_r) * 36'(bw_r);
  assign base_prod = 52'(k_r) * 52'(tpl_rd);
  assign nl_prod   = 61'(base_r) * 61'(wl) + 61'(half);
  assign nr_prod   = 61'(base_r) * 61'(frac_r) + 61'(half);

  // saturating bin update, shared by both bins of an entry
  assign add_q     = (state_r == S_BW0) ? da_q_r[31:0] : db_q_r;
  assign add_ovf   = (state_r == S_BW0) ? satl_r : satr_r;
  assign add_sum   = {1'b0, bin_rd} + {1'b0, add_q};
  assign add_sat   = add_ovf || add_sum[32];
  assign bin_wdata = add_sat ? 32'hFFFF_FFFF : add_sum[31:0];
  assign bin_waddr = (state_r == S_BW0) ? bidx_r[BA_W-1:0] : bidx1[BA_W-1:0];

  assign tpl_raddr = ent_r[TA_W-1:0];
  assign tpl_waddr = TA_W'(in_entry_index);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    out_strobe_nxt = 1'b0;
    out_value_nxt  = 32'd0;
    out_status_nxt = pth_pkg::STAT_DONE;
    amp_nxt        = amp_r;
    diff_nxt       = diff_r;
    acc_nxt        = acc_r;
    sum_nxt        = sum_r;
    pend_nxt       = pend_r;
    ent_nxt        = ent_r;
    dv_nxt         = dv_r;
    cnt_nxt        = cnt_r;
    da_rem_nxt     = da_rem_r;
    da_num_nxt     = da_num_r;
    da_q_nxt       = da_q_r;
    db_rem_nxt     = db_rem_r;
    db_num_nxt     = db_num_r;
    db_q_nxt       = db_q_r;
    bidx_nxt       = bidx_r;
    frac_nxt       = frac_r;
    k_nxt          = k_r;
    base_nxt       = base_r;
    nl_nxt         = nl_r;
    nr_nxt         = nr_r;
    satl_nxt       = satl_r;
    satr_nxt       = satr_r;
    in0_nxt        = in0_r;
    in1_nxt        = in1_r;
    sat_any_nxt    = sat_any_r;
    tpl_we         = 1'b0;
    bin_we         = 1'b0;
    bin_clr        = 1'b0;
    bin_raddr      = BA_W'(in_entry_index);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (pth_pkg::action_t'(in_action))
            pth_pkg::ACT_LOAD: begin
              out_strobe_nxt = 1'b1;
              if (32'(in_entry_index) < pth_pkg::TEMPLATE_LEN) begin
                tpl_we = 1'b1;
              end else begin
                out_status_nxt = pth_pkg::STAT_RANGE;
              end
            end
            pth_pkg::ACT_DEPOSIT: begin
              amp_nxt   = in_pulse_amplitude;
              diff_nxt  = {in_pulse_time[31], in_pulse_time} - {ws_r[31], ws_r};
              acc_nxt   = '0;
              ent_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SUM;
            end
            pth_pkg::ACT_READ: begin
              if (32'(in_entry_index) < 32'(nb_eff)) begin
                state_nxt = S_RDOUT;
              end else begin
                out_strobe_nxt = 1'b1;
                out_status_nxt = pth_pkg::STAT_RANGE;
              end
            end
            pth_pkg::ACT_CLEAR: begin
              bin_clr        = 1'b1;
              out_strobe_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_RDOUT: begin
        out_strobe_nxt = 1'b1;
        out_value_nxt  = bin_rd;
        state_nxt      = S_IDLE;
      end

      // template sum: one entry read per cycle, added in the cycle after its read
      S_SUM: begin
        if (pend_r) begin
          acc_nxt = acc_r + SX_W'(tpl_rd);
        end
        if (ent_r < ne_eff) begin
          ent_nxt  = ent_r + NE_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = S_CHECK;
          end
        end
      end

      S_CHECK: begin
        sum_nxt = sum_sat;
        if (amp_r == 20'd0 || sum_sat == 22'd0 || bw_r == 16'd0) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = pth_pkg::STAT_SKIPPED;
          state_nxt      = S_IDLE;
        end else begin
          dv_nxt     = 30'(bw_r);
          da_rem_nxt = '0;
          da_num_nxt = {mag, 8'd0};
          da_q_nxt   = '0;
          cnt_nxt    = CNT_W'(POS_STEPS);
          state_nxt  = S_PDIV;
        end
      end

      // |diff| * 256 / bin_width
      S_PDIV: begin
        da_rem_nxt = step_a.rem;
        da_num_nxt = {da_num_r[39:0], 1'b0};
        da_q_nxt   = {da_q_r[39:0], step_a.qbit};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_POS;
        end
      end

      S_POS: begin
        bidx_nxt    = {pos[41], pos[41:8]};
        frac_nxt    = pos[7:0];
        k_nxt       = k_prod;
        ent_nxt     = '0;
        sat_any_nxt = 1'b0;
        state_nxt   = S_ERD;
      end

      // template entry read; entries with both bins outside are passed over
      S_ERD: begin
        in0_nxt = in0_now;
        in1_nxt = in1_now;
        if (in0_now || in1_now) begin
          state_nxt = S_EMUL1;
        end else begin
          state_nxt = S_NEXT;
        end
      end

      S_EMUL1: begin
        base_nxt  = base_prod;
        state_nxt = S_EMUL2;
      end

      S_EMUL2: begin
        nl_nxt    = nl_prod;
        nr_nxt    = nr_prod;
        state_nxt = S_ELOAD;
      end

      // quotient >= 2^32 only when the top bits already reach the divisor
      S_ELOAD: begin
        satl_nxt   = ({1'b0, nl_r[60:32]} >= den);
        satr_nxt   = ({1'b0, nr_r[60:32]} >= den);
        dv_nxt     = den;
        da_rem_nxt = {1'b0, nl_r[60:32]};
        da_num_nxt = {nl_r[31:0], 9'd0};
        da_q_nxt   = '0;
        db_rem_nxt = {1'b0, nr_r[60:32]};
        db_num_nxt = nr_r[31:0];
        db_q_nxt   = '0;
        cnt_nxt    = CNT_W'(Q_STEPS);
        state_nxt  = S_EDIV;
      end

      S_EDIV: begin
        da_rem_nxt = step_a.rem;
        da_num_nxt = {da_num_r[39:0], 1'b0};
        da_q_nxt   = {da_q_r[39:0], step_a.qbit};
        db_rem_nxt = step_b.rem;
        db_num_nxt = {db_num_r[30:0], 1'b0};
        db_q_nxt   = {db_q_r[30:0], step_b.qbit};
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        if (in0_r) begin
          bin_raddr = bidx_r[BA_W-1:0];
          state_nxt = S_BW0;
        end else begin
          bin_raddr = bidx1[BA_W-1:0];
          state_nxt = S_BW1;
        end
      end

      // left bin written while the right bin is read
      S_BW0: begin
        bin_we      = 1'b1;
        sat_any_nxt = sat_any_r || add_sat;
        bin_raddr   = bidx1[BA_W-1:0];
        state_nxt   = in1_r ? S_BW1 : S_NEXT;
      end

      S_BW1: begin
        bin_we      = 1'b1;
        sat_any_nxt = sat_any_r || add_sat;
        state_nxt   = S_NEXT;
      end

      S_NEXT: begin
        if (NE_W'(ent_r + NE_W'(1)) == ne_eff) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = sat_any_r ? pth_pkg::STAT_SATURATED : pth_pkg::STAT_DONE;
          state_nxt      = S_IDLE;
        end else begin
          ent_nxt   = ent_r + NE_W'(1);
          bidx_nxt  = bidx1;
          state_nxt = S_ERD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      ws_r         <= pth_pkg::RST_WINDOW_START;
      bw_r         <= pth_pkg::RST_BIN_WIDTH;
      biu_r        <= pth_pkg::RST_BINS_IN_USE;
      tl_r         <= pth_pkg::RST_TEMPLATE_LENGTH;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (pth_pkg::cfg_idx_t'(cfg_index))
          pth_pkg::CFG_WINDOW_START:    ws_r  <= cfg_wdata;
          pth_pkg::CFG_BIN_WIDTH:       bw_r  <= cfg_wdata[15:0];
          pth_pkg::CFG_BINS_IN_USE:     biu_r <= cfg_wdata[8:0];
          pth_pkg::CFG_TEMPLATE_LENGTH: tl_r  <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  // valid bits stand in for clearing both stores
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpl_vld_r <= '0;
      bin_vld_r <= '0;
    end else begin
      if (tpl_we) begin
        tpl_vld_r[tpl_waddr] <= 1'b1;
      end
      if (bin_clr) begin
        bin_vld_r <= '0;
      end else if (bin_we) begin
        bin_vld_r[bin_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    tpl_vld_q_r  <= tpl_vld_r[tpl_raddr];
    bin_vld_q_r  <= bin_vld_r[bin_raddr];
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    amp_r        <= amp_nxt;
    diff_r       <= diff_nxt;
    acc_r        <= acc_nxt;
    sum_r        <= sum_nxt;
    pend_r       <= pend_nxt;
    ent_r        <= ent_nxt;
    dv_r         <= dv_nxt;
    cnt_r        <= cnt_nxt;
    da_rem_r     <= da_rem_nxt;
    da_num_r     <= da_num_nxt;
    da_q_r       <= da_q_nxt;
    db_rem_r     <= db_rem_nxt;
    db_num_r     <= db_num_nxt;
    db_q_r       <= db_q_nxt;
    bidx_r       <= bidx_nxt;
    frac_r       <= frac_nxt;
    k_r          <= k_nxt;
    base_r       <= base_nxt;
    nl_r         <= nl_nxt;
    nr_r         <= nr_nxt;
    satl_r       <= satl_nxt;
    satr_r       <= satr_nxt;
    in0_r        <= in0_nxt;
    in1_r        <= in1_nxt;
    sat_any_r    <= sat_any_nxt;
  end

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  pth_ram #(
    .WIDTH (16),
    .DEPTH (pth_pkg::TEMPLATE_LEN)
  ) u_tpl_ram (
    .clk   (clk),
    .we    (tpl_we),
    .waddr (tpl_waddr),
    .wdata (in_template_value),
    .raddr (tpl_raddr),
    .rdata (tpl_rdata)
  );

  pth_ram #(
    .WIDTH (32),
    .DEPTH (pth_pkg::NUM_BINS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  assign out_strobe    = out_strobe_r;
  assign out_bin_value = out_value_r;
  assign out_status    = out_status_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CHK_NEXT(a_quick_result, clk, rst_n, accept && (in_action == pth_pkg::ACT_LOAD || in_action == pth_pkg::ACT_CLEAR), out_strobe)
  `CHK_NEXT(a_deposit_busy, clk, rst_n, accept && in_action == pth_pkg::ACT_DEPOSIT, busy)
  `CHK_IMPL(a_no_result_busy, clk, rst_n, busy, !out_strobe)
  `CHK_IMPL(a_value_done, clk, rst_n, out_strobe && (out_bin_value != 32'd0), out_status == pth_pkg::STAT_DONE)
  `CHK_IMPL(a_div_count, clk, rst_n, state_r == S_PDIV || state_r == S_EDIV, cnt_r != '0)

endmodule

`default_nettype wire

[tb/pulse_template_histogram_splat_tb.sv]
`default_nettype none

module pulse_template_histogram_splat_tb;
  import pth_pkg::*;

  // one input transaction as it sits on the in_ ports
  typedef struct packed {
    action_t     action;
    logic [7:0]  entry_index;
    logic [15:0] template_value;
    logic [31:0] pulse_time;
    logic [19:0] pulse_amplitude;
  } pulse_cmd_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] bin_value;
    status_t     status;
  } bin_result_t;

  // Mirror of the template store, its running sum and the histogram.
  // note_input() applies one command and queues the result it must give;
  // check_result() pops the oldest queued result and compares it.
  class histogram_scoreboard;
    logic [15:0]  tmpl [TEMPLATE_LEN];
    logic [SUM_W-1:0] tsum;
    logic [31:0]  hist [NUM_BINS];
    logic [31:0]  window_start;
    logic [15:0]  bin_width;
    logic [8:0]   bins_in_use;
    logic [6:0]   template_length;
    bin_result_t  pending [$];
    int           errors;

    function new();
      foreach (tmpl[j]) tmpl[j] = '0;
      foreach (hist[j]) hist[j] = '0;
      tsum            = '0;
      window_start    = RST_WINDOW_START;
      bin_width       = RST_BIN_WIDTH;
      bins_in_use     = RST_BINS_IN_USE;
      template_length = RST_TEMPLATE_LENGTH;
      errors          = 0;
    endfunction

    function int used_entries();
      return (template_length < TEMPLATE_LEN) ? int'(template_length) : TEMPLATE_LEN;
    endfunction

    function int active_bins();
      return (bins_in_use < NUM_BINS) ? int'(bins_in_use) : NUM_BINS;
    endfunction

    // sum of the used entries, clamped to the sum register
    function void refresh_sum();
      longint unsigned s;
      int j;
      s = 0;
      for (j = 0; j < used_entries(); j++) s += tmpl[j];
      tsum = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // saturating add into an active bin; returns 1 when the bin clipped
    function bit add_bin(longint idx, longint unsigned v, int nb);
      longint unsigned s;
      add_bin = 1'b0;
      if (idx >= 0 && idx < nb) begin
        s = hist[idx];
        s = s + v;
        if (s > 64'hFFFF_FFFF) begin
          hist[idx] = '1;
          add_bin = 1'b1;
        end else begin
          hist[idx] = s[31:0];
        end
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        CFG_WINDOW_START:    window_start = data;
        CFG_BIN_WIDTH:       bin_width = data[15:0];
        CFG_BINS_IN_USE:     bins_in_use = data[8:0];
        CFG_TEMPLATE_LENGTH: begin
          template_length = data[6:0];
          refresh_sum();
        end
        default: ;
      endcase
    endfunction

    function void note_input(pulse_cmd_t c);
      bin_result_t r;
      longint num, pos, i0, bw;
      longint unsigned amp, base, frac, den;
      bit sat;
      int n, nb, j;
      r.bin_value = '0;
      r.status    = STAT_DONE;
      n  = used_entries();
      nb = active_bins();
      case (c.action)
        ACT_LOAD: begin
          if (c.entry_index < TEMPLATE_LEN) begin
            tmpl[c.entry_index] = c.template_value;
            refresh_sum();
          end else begin
            r.status = STAT_RANGE;
          end
        end
        ACT_DEPOSIT: begin
          amp = c.pulse_amplitude;
          bw  = bin_width;
          if (amp == 0 || tsum == 0 || bw == 0) begin
            r.status = STAT_SKIPPED;
          end else begin
            // position in 1/256 bin, floored toward minus infinity
            num = (longint'($signed(c.pulse_time)) - longint'($signed(window_start))) * 256;
            if (num >= 0) pos = num / bw;
            else          pos = -((-num + bw - 1) / bw);
            i0   = pos >>> 8;
            frac = pos & 255;
            den  = longint'(tsum) * 256;
            sat  = 1'b0;
            for (j = 0; j < n; j++) begin
              base = amp * tmpl[j] * bin_width;
              sat |= add_bin(i0 + j, (base * (256 - frac) + den / 2) / den, nb);
              sat |= add_bin(i0 + j + 1, (base * frac + den / 2) / den, nb);
            end
            r.status = sat ? STAT_SATURATED : STAT_DONE;
          end
        end
        ACT_READ: begin
          if (c.entry_index < nb) r.bin_value = hist[c.entry_index];
          else                    r.status = STAT_RANGE;
        end
        default: begin
          foreach (hist[j2]) hist[j2] = '0;
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] v, logic [1:0] s);
      bin_result_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with nothing pending: bin_value %h status %0d", $time, v, s);
      end else begin
        e = pending.pop_front();
        if (e.bin_value !== v) begin
          errors++;
          $display("%0t: bin_value mismatch: expected %h actual %h", $time, e.bin_value, v);
        end
        if (e.status !== s) begin
          errors++;
          $display("%0t: status mismatch: expected %0d actual %0d", $time, e.status, s);
        end
      end
    endfunction
  endclass

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 235;
  // the limit leaves a wide margin over the longest deposit (64 entries, all in range)
  localparam int STALL_LIMIT     = 20000;
  localparam int DRAIN_CYCLES    = 64;
  // the block decodes only four registers; this one must be ignored
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = ACT_LOAD;
  logic [7:0]  in_entry_index = '0;
  logic [15:0] in_template_value = '0;
  logic signed [31:0] in_pulse_time = '0;
  logic [19:0] in_pulse_amplitude = '0;
  logic        out_strobe;
  logic [31:0] out_bin_value;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_WINDOW_START;
  logic [31:0] cfg_wdata = '0;

  histogram_scoreboard sb;
  int idle_pct = 32;
  int quiet_cycles = 0;

  pulse_template_histogram_splat dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_entry_index    (in_entry_index),
    .in_template_value (in_template_value),
    .in_pulse_time     (in_pulse_time),
    .in_pulse_amplitude(in_pulse_amplitude),
    .out_strobe        (out_strobe),
    .out_bin_value     (out_bin_value),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: the receiver never stalls, so every strobe cycle is a
  // transaction and is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_bin_value, out_status);
  end

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_strobe)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic pulse_cmd_t make_cmd(action_t a, logic [7:0] idx, logic [15:0] tv,
                                          logic [31:0] pt, logic [19:0] amp);
    make_cmd.action          = a;
    make_cmd.entry_index     = idx;
    make_cmd.template_value  = tv;
    make_cmd.pulse_time      = pt;
    make_cmd.pulse_amplitude = amp;
  endfunction

  // Present one command, with a random gap ahead of it; returns in the time
  // step of the edge that accepted it, start still high. The caller either
  // sends the next command or lowers start in that same step.
  task automatic send_cmd(pulse_cmd_t c);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_action          <= c.action;
    in_entry_index     <= c.entry_index;
    in_template_value  <= c.template_value;
    in_pulse_time      <= c.pulse_time;
    in_pulse_amplitude <= c.pulse_amplitude;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(c);
  endtask

  // drop start and wait until every result is back and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0 || busy);
  endtask

  // one register write per cycle; caller lowers cfg_we after the group
  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  initial begin
    pulse_cmd_t  c;
    int          p, i, k, n, nb, bwi, pick;
    logic [31:0] ws;
    logic [15:0] bw;
    logic [8:0]  nbins;
    logic [6:0]  tlen;

    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: reset config (window 0, width 1, 256 bins, 64 entries)
    send_cmd(make_cmd(ACT_READ,    8'd0,   '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd255, '0, '0, '0));
    // empty template: sum is zero, deposit skipped
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'hFFFFF));
    // template index past the store
    send_cmd(make_cmd(ACT_LOAD,    8'd64,  16'h1234, '0, '0));
    send_cmd(make_cmd(ACT_LOAD,    8'd255, 16'hFFFF, '0, '0));
    send_cmd(make_cmd(ACT_LOAD,    8'd0,   16'hFFFF, '0, '0));
    send_cmd(make_cmd(ACT_LOAD,    8'd63,  16'h8000, '0, '0));
    send_cmd(make_cmd(ACT_LOAD,    8'd31,  16'h0001, '0, '0));
    // zero amplitude is skipped
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'd0));
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'hFFFFF));
    // starts one bin left of the window
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'hFFFF_FFFF, 20'h00100));
    // starts in the last bin, nearly all entries fall off the right end
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd255, 20'hFFFFF));
    // extremes of time: entirely outside
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'h8000_0000, 20'hFFFFF));
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'h7FFF_FFFF, 20'd1));
    send_cmd(make_cmd(ACT_READ,    8'd0,   '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd1,   '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd64,  '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd255, '0, '0, '0));
    send_cmd(make_cmd(ACT_CLEAR,   8'd0,   '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd0,   '0, '0, '0));

    // zero bin width: deposit skipped; also poke an undecoded index
    wait_idle();
    cfg_write(CFG_UNUSED, 32'hFFFF_FFFF);
    cfg_write(CFG_BIN_WIDTH, 32'd0);
    cfg_we <= 1'b0;
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'hFFFFF));

    // widest bins: one deposit clips bin 0
    wait_idle();
    cfg_write(CFG_BIN_WIDTH, 32'h0000_FFFF);
    cfg_we <= 1'b0;
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'hFFFFF));
    send_cmd(make_cmd(ACT_READ,    8'd0,   '0, '0, '0));

    // negative window, width 3: fractional start splits into both bins
    wait_idle();
    cfg_write(CFG_WINDOW_START, 32'hFFFF_FFFB);
    cfg_write(CFG_BIN_WIDTH, 32'd3);
    cfg_we <= 1'b0;
    send_cmd(make_cmd(ACT_CLEAR,   8'd0,   '0, '0, '0));
    send_cmd(make_cmd(ACT_DEPOSIT, 8'd0,   '0, 32'd0, 20'hFFFFF));
    send_cmd(make_cmd(ACT_READ,    8'd1,   '0, '0, '0));
    send_cmd(make_cmd(ACT_READ,    8'd2,   '0, '0, '0));

    // ---- random phases, each with its own register setting
    for (p = 0; p < PHASES; p++) begin
      // sender gaps: 32% for the first phases, then 61%, then none
      idle_pct = (p < 3) ? 32 : (p < 6) ? 61 : 0;
      case (p)
        0: begin ws = $urandom_range(0, 1000); bw = 16'd1; nbins = 9'd256; tlen = 7'd8; end
        1: begin
          ws = $urandom; bw = 16'($urandom_range(2, 16));
          nbins = 9'($urandom_range(1, 256)); tlen = 7'($urandom_range(1, 8));
        end
        // extremes: most negative window, widest bins, one bin, one entry
        2: begin ws = 32'h8000_0000; bw = 16'hFFFF; nbins = 9'd1; tlen = 7'd1; end
        // over-range bin count clamps to the array size
        3: begin ws = 32'h7FFF_FFFF; bw = 16'd1; nbins = 9'h1FF; tlen = 7'd16; end
        4: begin
          ws = $urandom; bw = 16'($urandom_range(1, 65535));
          nbins = 9'($urandom_range(200, 256)); tlen = 7'h7F;
        end
        // zero width, bins and entries: reads out of range, deposits skipped
        5: begin ws = $urandom; bw = 16'd0; nbins = 9'd0; tlen = 7'd0; end
        6: begin
          ws = $urandom; bw = 16'($urandom_range(1, 300));
          nbins = 9'($urandom_range(2, 64)); tlen = 7'($urandom_range(2, 12));
        end
        default: begin
          ws = $urandom; bw = 16'($urandom_range(1, 8));
          nbins = 9'd256; tlen = 7'($urandom_range(1, 4));
        end
      endcase
      wait_idle();
      cfg_write(CFG_WINDOW_START, ws);
      cfg_write(CFG_BIN_WIDTH, {16'd0, bw});
      cfg_write(CFG_BINS_IN_USE, {23'd0, nbins});
      cfg_write(CFG_TEMPLATE_LENGTH, {25'd0, tlen});
      cfg_we <= 1'b0;

      n   = sb.used_entries();
      nb  = sb.active_bins();
      bwi = sb.bin_width;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // fill every field with noise, then shape the ones the action uses
        c.entry_index     = 8'($urandom);
        c.template_value  = 16'($urandom);
        c.pulse_time      = $urandom;
        c.pulse_amplitude = 20'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          c.action = ACT_LOAD;
          pick = $urandom_range(0, 9);
          if (pick < 5 && n > 0)  c.entry_index = 8'($urandom_range(0, n - 1));
          else if (pick < 8)      c.entry_index = 8'($urandom_range(0, TEMPLATE_LEN - 1));
          pick = $urandom_range(0, 9);
          if (pick == 0)      c.template_value = '0;
          else if (pick == 1) c.template_value = '1;
        end else if (pick < 60) begin
          c.action = ACT_DEPOSIT;
          pick = $urandom_range(0, 19);
          if (pick == 0)     c.pulse_amplitude = '0;
          else if (pick < 8) c.pulse_amplitude = 20'($urandom_range(1, 4095));
          // most pulses land so that the template overlaps the active bins
          if ($urandom_range(0, 9) < 8 && bwi > 0) begin
            k = int'($urandom_range(0, nb + n + 2)) - (n + 2);
            c.pulse_time = sb.window_start + 32'(k * bwi) + 32'($urandom_range(0, bwi - 1));
          end
        end else if (pick < 95) begin
          c.action = ACT_READ;
          if ($urandom_range(0, 9) < 7 && nb > 0) c.entry_index = 8'($urandom_range(0, nb - 1));
        end else begin
          c.action = ACT_CLEAR;
        end
        send_cmd(c);
      end
    end

    wait_idle();
    // late or extra results would show up here as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
